// ----- design/circumcenter_three_points_defines.svh -----
// Assertion macros for the circumcenter block.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef CIRCUMCENTER_THREE_POINTS_DEFINES_SVH
`define CIRCUMCENTER_THREE_POINTS_DEFINES_SVH

`ifndef ASSERT_OFF
`define CC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("circumcenter assertion failed");
`define CC_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("circumcenter reset assertion failed");
`else
`define CC_ASSERT(lbl, prop)
`define CC_ASSERT_RST(lbl, prop)
`endif

`endif

// ----- design/cc_pkg.sv -----
// Shared widths, codes and types for the circumcenter block.
// Used by the front pipeline, the divider cells and the top level.
`timescale 1ns / 1ps
`default_nettype none

package cc_pkg;

  localparam int PT_W   = 24;
  localparam int DIF_W  = PT_W + 1;
  localparam int SQ1_W  = 2 * DIF_W - 1;
  localparam int XP_W   = 2 * DIF_W;
  localparam int SQ_W   = 50;
  localparam int CRS_W  = 51;
  localparam int DEN_W  = CRS_W + 1;
  localparam int PP_W   = 52;
  localparam int NUM_W  = 80;
  localparam int CEN_W  = 40;
  localparam int CFG_W  = 50;
  localparam int APB_W  = 64;
  localparam int ADDR_W = 4;
  localparam int IN_W   = 6 * PT_W;
  localparam int N_CELLS = CEN_W;

  localparam logic REG_MIN_SIDE = 1'b0;
  localparam logic REG_COLLIN   = 1'b1;

  localparam logic [CEN_W-1:0] POS_LIM = {1'b0, {(CEN_W-1){1'b1}}};
  localparam logic [CEN_W-1:0] NEG_LIM = {1'b1, {(CEN_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_COINC  = 2'd1,
    ST_COLLIN = 2'd2
  } status_t;

  typedef struct packed {
    logic              valid;
    status_t           status;
    logic              ovx;
    logic              ovy;
    logic              negx;
    logic              negy;
    logic [DEN_W-1:0]  den;
    logic [DEN_W-1:0]  remx;
    logic [DEN_W-1:0]  remy;
    logic [CEN_W-1:0]  lowx;
    logic [CEN_W-1:0]  lowy;
  } cell_t;

  typedef struct packed {
    logic             clip;
    logic [CEN_W-1:0] val;
  } sat_t;

  function automatic sat_t saturate(logic neg, logic ov, logic [CEN_W-1:0] q);
    sat_t r;
    if (neg) begin
      r.clip = ov || (q > NEG_LIM);
      r.val  = r.clip ? NEG_LIM : CEN_W'(0) - q;
    end else begin
      r.clip = ov || q[CEN_W-1];
      r.val  = r.clip ? POS_LIM : q;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/cc_front.sv -----
// Front pipeline: differences, squares, checks, numerators and magnitudes.
// Depends on cc_pkg; feeds the first divider cell with a cell_t transfer.
`timescale 1ns / 1ps
`default_nettype none

module cc_front (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire logic                    in_valid,
  input  wire logic [cc_pkg::IN_W-1:0] pts,
  input  wire logic [cc_pkg::CFG_W-1:0] min_side,
  input  wire logic [cc_pkg::CFG_W-1:0] collin_lim,
  output cc_pkg::cell_t                dout
);
  import cc_pkg::*;

  logic signed [PT_W-1:0] ix1, iy1, ix2, iy2, ix3, iy3;
  assign ix1 = pts[PT_W-1:0];
  assign iy1 = pts[2*PT_W-1:PT_W];
  assign ix2 = pts[3*PT_W-1:2*PT_W];
  assign iy2 = pts[4*PT_W-1:3*PT_W];
  assign ix3 = pts[5*PT_W-1:4*PT_W];
  assign iy3 = pts[6*PT_W-1:5*PT_W];

  logic [7:1] v;

  logic signed [PT_W-1:0]  x1_1, y1_1, x1_2, y1_2, x1_3, y1_3;
  logic signed [DIF_W-1:0] bx1, by1, cx1, cy1, vx1, vy1;
  logic signed [DIF_W-1:0] bx2, by2, cx2, cy2, bx3, by3, cx3, cy3;
  logic [SQ1_W-1:0]        bxx, byy, cxx, cyy, vxx, vyy;
  logic signed [XP_W-1:0]  pbc, pcb;
  logic [SQ_W-1:0]         bb, cc, vv;
  logic signed [CRS_W-1:0] crs;
  logic [CRS_W-1:0]        crs_mag;
  status_t                 st_comb;
  logic signed [DEN_W-1:0] d_comb;

  status_t                 st4, st5, st6, st7;
  logic signed [DEN_W-1:0] d4, d5, d6;
  logic signed [PP_W-1:0]  x1dl, x1dh, y1dl, y1dh;
  logic signed [PP_W-1:0]  cybl, cybh, bycl, bych, bxcl, bxch, cxbl, cxbh;
  logic signed [NUM_W-1:0] ax, bxn, cxn, ay, byn, cyn;
  logic signed [NUM_W-1:0] nx, ny;
  logic [NUM_W-1:0]        mx, my;
  logic [DEN_W-1:0]        den7;
  logic                    negx7, negy7;

  assign crs_mag = crs[CRS_W-1] ? CRS_W'(-crs) : CRS_W'(crs);
  assign d_comb  = {crs, 1'b0};

  always_comb begin
    if (bb < min_side || vv < min_side || cc < min_side) begin
      st_comb = ST_COINC;
    end else if (crs_mag <= {1'b0, collin_lim}) begin
      st_comb = ST_COLLIN;
    end else begin
      st_comb = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v          <= '0;
      dout.valid <= 1'b0;
    end else if (en) begin
      v          <= {v[6:1], in_valid};
      dout.valid <= v[7];
    end

    if (en) begin
      x1_1 <= ix1;
      y1_1 <= iy1;
      bx1  <= DIF_W'(ix2) - DIF_W'(ix1);
      by1  <= DIF_W'(iy2) - DIF_W'(iy1);
      cx1  <= DIF_W'(ix3) - DIF_W'(ix1);
      cy1  <= DIF_W'(iy3) - DIF_W'(iy1);
      vx1  <= DIF_W'(ix3) - DIF_W'(ix2);
      vy1  <= DIF_W'(iy3) - DIF_W'(iy2);

      x1_2 <= x1_1;
      y1_2 <= y1_1;
      bx2  <= bx1;
      by2  <= by1;
      cx2  <= cx1;
      cy2  <= cy1;
      bxx  <= SQ1_W'(bx1 * bx1);
      byy  <= SQ1_W'(by1 * by1);
      cxx  <= SQ1_W'(cx1 * cx1);
      cyy  <= SQ1_W'(cy1 * cy1);
      vxx  <= SQ1_W'(vx1 * vx1);
      vyy  <= SQ1_W'(vy1 * vy1);
      pbc  <= bx1 * cy1;
      pcb  <= by1 * cx1;

      x1_3 <= x1_2;
      y1_3 <= y1_2;
      bx3  <= bx2;
      by3  <= by2;
      cx3  <= cx2;
      cy3  <= cy2;
      bb   <= SQ_W'(bxx) + SQ_W'(byy);
      cc   <= SQ_W'(cxx) + SQ_W'(cyy);
      vv   <= SQ_W'(vxx) + SQ_W'(vyy);
      crs  <= CRS_W'(pbc) - CRS_W'(pcb);

      st4  <= st_comb;
      d4   <= d_comb;
      x1dl <= PP_W'(x1_3 * $signed({1'b0, d_comb[25:0]}));
      x1dh <= PP_W'(x1_3 * $signed(d_comb[DEN_W-1:26]));
      y1dl <= PP_W'(y1_3 * $signed({1'b0, d_comb[25:0]}));
      y1dh <= PP_W'(y1_3 * $signed(d_comb[DEN_W-1:26]));
      cybl <= PP_W'(cy3 * $signed({1'b0, bb[24:0]}));
      cybh <= PP_W'(cy3 * $signed({1'b0, bb[SQ_W-1:25]}));
      bycl <= PP_W'(by3 * $signed({1'b0, cc[24:0]}));
      bych <= PP_W'(by3 * $signed({1'b0, cc[SQ_W-1:25]}));
      bxcl <= PP_W'(bx3 * $signed({1'b0, cc[24:0]}));
      bxch <= PP_W'(bx3 * $signed({1'b0, cc[SQ_W-1:25]}));
      cxbl <= PP_W'(cx3 * $signed({1'b0, bb[24:0]}));
      cxbh <= PP_W'(cx3 * $signed({1'b0, bb[SQ_W-1:25]}));

      st5 <= st4;
      d5  <= d4;
      ax  <= (NUM_W'(x1dh) <<< 26) + NUM_W'(x1dl);
      bxn <= (NUM_W'(cybh) <<< 25) + NUM_W'(cybl);
      cxn <= (NUM_W'(bych) <<< 25) + NUM_W'(bycl);
      ay  <= (NUM_W'(y1dh) <<< 26) + NUM_W'(y1dl);
      byn <= (NUM_W'(bxch) <<< 25) + NUM_W'(bxcl);
      cyn <= (NUM_W'(cxbh) <<< 25) + NUM_W'(cxbl);

      st6 <= st5;
      d6  <= d5;
      nx  <= ax + bxn - cxn;
      ny  <= ay + byn - cyn;

      st7   <= st6;
      mx    <= nx[NUM_W-1] ? NUM_W'(-nx) : NUM_W'(nx);
      my    <= ny[NUM_W-1] ? NUM_W'(-ny) : NUM_W'(ny);
      den7  <= d6[DEN_W-1] ? DEN_W'(-d6) : DEN_W'(d6);
      negx7 <= nx[NUM_W-1] ^ d6[DEN_W-1];
      negy7 <= ny[NUM_W-1] ^ d6[DEN_W-1];

      dout.status <= st7;
      dout.ovx    <= DEN_W'(mx[NUM_W-1:CEN_W]) >= den7;
      dout.ovy    <= DEN_W'(my[NUM_W-1:CEN_W]) >= den7;
      dout.negx   <= negx7;
      dout.negy   <= negy7;
      dout.den    <= den7;
      dout.remx   <= DEN_W'(mx[NUM_W-1:CEN_W]);
      dout.remy   <= DEN_W'(my[NUM_W-1:CEN_W]);
      dout.lowx   <= mx[CEN_W-1:0];
      dout.lowy   <= my[CEN_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- design/cc_div_cell.sv -----
// One cell of the divider chain: one quotient bit for each coordinate.
// Depends on cc_pkg; chained by the top level.
`timescale 1ns / 1ps
`default_nettype none

module cc_div_cell (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   en,
  input  wire cc_pkg::cell_t din,
  output cc_pkg::cell_t dout
);
  import cc_pkg::*;

  logic [DEN_W:0] tx, ty, dfx, dfy;
  logic           gex, gey;

  assign tx  = {din.remx, din.lowx[CEN_W-1]};
  assign ty  = {din.remy, din.lowy[CEN_W-1]};
  assign dfx = tx - {1'b0, din.den};
  assign dfy = ty - {1'b0, din.den};
  assign gex = tx >= {1'b0, din.den};
  assign gey = ty >= {1'b0, din.den};

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end

    if (en) begin
      dout.status <= din.status;
      dout.ovx    <= din.ovx;
      dout.ovy    <= din.ovy;
      dout.negx   <= din.negx;
      dout.negy   <= din.negy;
      dout.den    <= din.den;
      dout.remx   <= gex ? dfx[DEN_W-1:0] : tx[DEN_W-1:0];
      dout.remy   <= gey ? dfy[DEN_W-1:0] : ty[DEN_W-1:0];
      dout.lowx   <= {din.lowx[CEN_W-2:0], gex};
      dout.lowy   <= {din.lowy[CEN_W-2:0], gey};
    end
  end

endmodule

`default_nettype wire

// ----- design/circumcenter_three_points.sv -----
// Circumcenter of three points in Q15.8: front pipeline, a divider chain and output stage.
// Depends on cc_pkg, cc_front, cc_div_cell and the assertion macro header.
//
// One point triple is taken per clock cycle unless the pipeline is stalled. Each result
// passes through eight front stages for differences, products, the coincident and
// collinear checks and the numerator magnitudes, forty divider cells that each
// produce one quotient bit, and the output register. The forty-cell divider chain is
// most of the pipeline depth. A full output register with a stalled consumer freezes
// the pipeline only when a finished result is waiting behind it.
`timescale 1ns / 1ps
`default_nettype none
`include "circumcenter_three_points_defines.svh"

module circumcenter_three_points (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  // first_x, first_y, second_x, second_y, third_x, third_y
  input  wire logic [cc_pkg::IN_W-1:0]    s_tdata,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  // center_x, center_y
  output logic [2*cc_pkg::CEN_W-1:0]      m_tdata,
  // status, clipped
  output logic [2:0]                      m_tuser,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [cc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [cc_pkg::APB_W-1:0]   pwdata,
  output logic [cc_pkg::APB_W-1:0]        prdata,
  output logic                            pready
);
  import cc_pkg::*;

  logic [CFG_W-1:0] min_side, collin_lim;
  logic             en;
  cell_t            chain [0:N_CELLS];
  cell_t            last;
  sat_t             sx, sy;

  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_COLLIN) ? APB_W'(collin_lim) : APB_W'(min_side);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_side   <= CFG_W'(1);
      collin_lim <= '0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[3] == REG_MIN_SIDE) begin
        min_side <= pwdata[CFG_W-1:0];
      end else begin
        collin_lim <= pwdata[CFG_W-1:0];
      end
    end
  end

  assign last     = chain[N_CELLS];
  assign en       = !m_tvalid || m_tready || !last.valid;
  assign s_tready = en;

  cc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (s_tvalid),
    .pts        (s_tdata),
    .min_side   (min_side),
    .collin_lim (collin_lim),
    .dout       (chain[0])
  );

  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    cc_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  assign sx = saturate(last.negx, last.ovx, last.lowx);
  assign sy = saturate(last.negy, last.ovy, last.lowy);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en && last.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && last.valid) begin
      if (last.status == ST_OK) begin
        m_tdata <= {sy.val, sx.val};
        m_tuser <= {sx.clip || sy.clip, last.status};
      end else begin
        m_tdata <= '0;
        m_tuser <= {1'b0, last.status};
      end
    end
  end

  `CC_ASSERT(a_bad_zero, m_tvalid && (m_tuser[1:0] != ST_OK) |-> (m_tdata == '0) && !m_tuser[2])
  `CC_ASSERT(a_clip_lim, m_tvalid && m_tuser[2] |-> (m_tdata[CEN_W-1:0] == POS_LIM) || (m_tdata[CEN_W-1:0] == NEG_LIM) || (m_tdata[2*CEN_W-1:CEN_W] == POS_LIM) || (m_tdata[2*CEN_W-1:CEN_W] == NEG_LIM))
  `CC_ASSERT(a_hold_stall, last.valid && m_tvalid && !m_tready |-> !s_tready)
  `CC_ASSERT_RST(a_rst_idle, rst |=> !m_tvalid && !last.valid)

endmodule

`default_nettype wire

// ----- bench/circumcenter_three_points_test.sv -----
// Self-checking bench for circumcenter_three_points: point triples in, circle centers out.
// Computes each expected center with exact wide arithmetic and compares per field.
// Depends on cc_pkg and the circumcenter_three_points RTL.
`timescale 1ns / 1ps

class center_scoreboard;
  typedef struct {
    logic signed [39:0] cx;
    logic signed [39:0] cy;
    cc_pkg::status_t    st;
    logic               clip;
  } center_t;

  center_t pending[$];
  int mismatches = 0;
  int checked = 0;
  int stray = 0;
  logic [49:0] min_side = 50'd1;
  logic [49:0] collin_lim = 50'd0;

  function void set_reg(int idx, logic [63:0] v);
    if (idx == cc_pkg::REG_MIN_SIDE) min_side = v[49:0];
    else if (idx == cc_pkg::REG_COLLIN) collin_lim = v[49:0];
  endfunction

  function logic signed [39:0] div_sat(logic signed [127:0] num, logic signed [127:0] den,
                                       inout logic clip);
    logic signed [127:0] q;
    q = num / den;
    if (q > 128'sh7FFFFFFFFF) begin
      clip = 1'b1;
      return cc_pkg::POS_LIM;
    end
    if (q < -128'sh8000000000) begin
      clip = 1'b1;
      return cc_pkg::NEG_LIM;
    end
    return q[39:0];
  endfunction

  function void note_triple(logic [143:0] d);
    logic signed [127:0] x1, y1, x2, y2, x3, y3, bx, by, cx, cy, vx, vy;
    logic signed [127:0] bb, cc, vv, crs, acrs, dd, nx, ny;
    center_t e;
    x1 = $signed(d[23:0]);    y1 = $signed(d[47:24]);
    x2 = $signed(d[71:48]);   y2 = $signed(d[95:72]);
    x3 = $signed(d[119:96]);  y3 = $signed(d[143:120]);
    bx = x2 - x1; by = y2 - y1; cx = x3 - x1; cy = y3 - y1; vx = x3 - x2; vy = y3 - y2;
    bb = bx * bx + by * by; cc = cx * cx + cy * cy; vv = vx * vx + vy * vy;
    crs = bx * cy - by * cx;
    acrs = crs < 0 ? -crs : crs;
    e.cx = '0; e.cy = '0; e.clip = 1'b0; e.st = cc_pkg::ST_OK;
    if (bb < $signed({78'd0, min_side}) || cc < $signed({78'd0, min_side}) ||
        vv < $signed({78'd0, min_side})) begin
      e.st = cc_pkg::ST_COINC;
    end else if (acrs <= $signed({78'd0, collin_lim})) begin
      e.st = cc_pkg::ST_COLLIN;
    end else begin
      dd = 2 * crs;
      nx = x1 * dd + cy * bb - by * cc;
      ny = y1 * dd + bx * cc - cx * bb;
      e.cx = div_sat(nx, dd, e.clip);
      e.cy = div_sat(ny, dd, e.clip);
    end
    pending.push_back(e);
  endfunction

  function void check_center(logic [79:0] data, logic [2:0] user);
    center_t e;
    if (pending.size() == 0) begin
      stray++;
      mismatches++;
      if (mismatches <= 10) $display("Unexpected result transfer: tdata=%h tuser=%h", data, user);
      return;
    end
    e = pending.pop_front();
    checked++;
    if (data[39:0] !== e.cx || data[79:40] !== e.cy || user[1:0] !== e.st ||
        user[2] !== e.clip) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch: expected x=%h y=%h st=%0d clip=%b, got x=%h y=%h st=%0d clip=%b",
                 e.cx, e.cy, e.st, e.clip, data[39:0], data[79:40], user[1:0], user[2]);
    end
  endfunction
endclass

module circumcenter_three_points_test;
  import cc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [2*CEN_W-1:0] m_tdata;
  logic [2:0] m_tuser;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [APB_W-1:0] pwdata = '0;
  logic [APB_W-1:0] prdata;
  logic pready;

  center_scoreboard board;
  int send_idle = 0;
  int recv_idle = 0;
  bit hold_off = 1'b0;
  int quiet = 0;
  int sent = 0;
  bit failed = 1'b0;

  always #6 clk = ~clk;

  circumcenter_three_points dut (.*);

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (s_tvalid && s_tready) board.note_triple(s_tdata);
      if (m_tvalid && m_tready) board.check_center(m_tdata, m_tuser);
    end
  end

  always @(posedge clk) begin
    m_tready <= !hold_off && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (quiet > 5000) begin
      $display("Watchdog expired with %0d results outstanding", board.pending.size());
      $display("circumcenter_three_points regression: fail");
      $finish;
    end
  end

  task automatic write_reg(int idx, logic [63:0] v);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_W'(8 * idx); pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    board.set_reg(idx, v);
  endtask

  task automatic send_triple(logic signed [23:0] x1, y1, x2, y2, x3, y3);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {y3, x3, y2, x2, y1, x1};
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic signed [23:0] rand_coord(int mode);
    case (mode)
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(4095)) - 2048);
      default: return 24'($urandom_range(1)) ? 24'sh7FFFFF - 24'($urandom_range(3))
                                             : 24'sh800000 + 24'($urandom_range(3));
    endcase
  endfunction

  task automatic send_random();
    logic signed [23:0] p[6];
    int mode;
    int k;
    mode = $urandom_range(9) < 6 ? 0 : ($urandom_range(2) == 0 ? 2 : 1);
    foreach (p[i]) p[i] = rand_coord(mode);
    k = $urandom_range(9);
    if (k == 0) begin
      p[2] = p[0] + 24'($urandom_range(1));
      p[3] = p[1];
    end else if (k == 1) begin
      p[4] = p[2] + (p[2] - p[0]);
      p[5] = p[3] + (p[3] - p[1]);
    end else if (k == 2) begin
      p[4] = p[2] + 24'($urandom_range(2));
      p[5] = p[3] + 24'($urandom_range(2));
    end
    send_triple(p[0], p[1], p[2], p[3], p[4], p[5]);
  endtask

  task automatic run_random(int n);
    repeat (n) send_random();
  endtask

  initial begin
    board = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle = 15; recv_idle = 50;
    send_triple(0, 0, 256, 0, 0, 256);
    send_triple(0, 0, 0, 0, 256, 256);
    send_triple(5, 5, 5, 5, 5, 5);
    send_triple(0, 0, 256, 256, 512, 512);
    send_triple(0, 0, 1, 0, 0, 1);
    send_triple(24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh7FFFFF, 24'sh800000);
    send_triple(24'sh800000, 24'sh800000, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000);
    send_triple(0, 0, 24'sh7FFFFF, 1, 24'sh800000, 0);
    send_triple(24'sh800000, 0, 24'sh7FFFFF, 0, 0, 1);
    send_triple(0, 0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFE, 24'sh7FFFFF);
    send_triple(-100, 300, 700, -250, 40, 900);
    send_triple(1, 1, 2, 3, 24'sh555555, 24'shAAAAAA);
    drain();

    write_reg(REG_MIN_SIDE, 64'd0);
    write_reg(REG_COLLIN, 64'h3_FFFF_FFFF_FFFF);
    send_triple(0, 0, 0, 0, 0, 0);
    send_triple(0, 0, 256, 0, 0, 256);
    run_random(40);
    drain();

    write_reg(REG_MIN_SIDE, 64'h3_FFFF_FFFF_FFFF);
    write_reg(REG_COLLIN, 64'd0);
    run_random(30);
    drain();

    write_reg(REG_MIN_SIDE, 64'd65536);
    write_reg(REG_COLLIN, 64'd1000000);
    send_idle = 50; recv_idle = 15;
    run_random(150);
    drain();

    write_reg(REG_MIN_SIDE, 64'd1);
    write_reg(REG_COLLIN, 64'd0);
    send_idle = 0; recv_idle = 0;
    hold_off = 1'b1;
    fork
      run_random(120);
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
    join
    run_random(110);
    drain();

    $display("Sent %0d point triples and checked %0d centers over four threshold settings,",
             sent, board.checked);
    $display("with sender and receiver idling, a long output stall and full-rate streaming.");
    failed = board.mismatches != 0 || board.pending.size() != 0;
    if (!failed) begin
      $display("circumcenter_three_points regression: pass");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("circumcenter_three_points regression: fail");
    end
    $finish;
  end
endmodule
